// File: hw/rtl/assert_macros.svh
// assertion macros shared by the scheduler rtl
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property checked every clock outside reset
`define PSA_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("scheduler assertion failed");

// antecedent implies consequent on the next clock
`define PSA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scheduler assertion failed");

`endif

// File: hw/rtl/psa_pkg.sv
// shared types, codes and constants of the priority scheduler
// no dependencies
package psa_pkg;

    localparam int DEF_LEVELS      = 4;
    localparam int DEF_QUEUE_DEPTH = 8;
    localparam int LVL_W           = 3;

    localparam logic [15:0] CUTOFF_RST    = 16'd100;
    localparam logic [3:0]  AGE_LIMIT_RST = 4'd5;
    localparam logic [3:0]  AGE_MAX       = 4'd15;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_CUTOFF    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_AGE_LIMIT = 1'b1;

    localparam logic REQ_ARRIVAL = 1'b0;
    localparam logic REQ_TICK    = 1'b1;

    typedef enum logic [2:0] {
        EV_SLICE  = 3'd0,
        EV_FINISH = 3'd1,
        EV_DROP   = 3'd2,
        EV_IDLE   = 3'd3,
        EV_REJECT = 3'd4
    } t_event;

    typedef struct packed {
        logic [7:0]       id;
        logic [LVL_W-1:0] lvl;
        logic [15:0]      arrival;
        logic [7:0]       service;
        logic [7:0]       remaining;
        logic [15:0]      start;
        logic [3:0]       age;
    } t_job;

    localparam int JOB_W = $bits(t_job);

    typedef struct packed {
        t_event      kind;
        logic [7:0]  id;
        logic [2:0]  prio;
        logic [15:0] arrival;
        logic [7:0]  service;
        logic [15:0] start;
        logic [15:0] end_tick;
        logic        last;
    } t_res;

    // queue pointer command, at most one operation per cycle
    typedef struct packed {
        logic             push;
        logic             pop;
        logic             drain;
        logic [LVL_W-1:0] lvl;
    } t_qcmd;

endpackage

// File: hw/rtl/psa_req_if.sv
// request channel of the scheduler: arrivals and clock ticks
// no dependencies
interface psa_req_if;
    logic       valid;
    logic       ready;
    logic       req_type;
    logic [7:0] job_id;
    logic [2:0] job_priority;
    logic [7:0] job_service;

    modport source (output valid, req_type, job_id, job_priority, job_service,
                    input ready);
    modport sink (input valid, req_type, job_id, job_priority, job_service,
                  output ready);
endinterface

// File: hw/rtl/psa_res_if.sv
// result channel of the scheduler: one event per transfer
// no dependencies
interface psa_res_if;
    logic        valid;
    logic        ready;
    logic [2:0]  event_kind;
    logic [7:0]  out_id;
    logic [2:0]  out_priority;
    logic [15:0] out_arrival;
    logic [7:0]  out_service;
    logic [15:0] out_start;
    logic [15:0] out_end;
    logic        last_result;

    modport source (output valid, event_kind, out_id, out_priority, out_arrival,
                    out_service, out_start, out_end, last_result, input ready);
    modport sink (input valid, event_kind, out_id, out_priority, out_arrival,
                  out_service, out_start, out_end, last_result, output ready);
endinterface

// File: hw/rtl/psa_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module psa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// File: hw/rtl/psa_qptr.sv
// head and count of every level queue, with derived tail slots
// depends on psa_pkg and assert_macros.svh
`include "assert_macros.svh"
module psa_qptr #(
    parameter int LEVELS      = psa_pkg::DEF_LEVELS,
    parameter int QUEUE_DEPTH = psa_pkg::DEF_QUEUE_DEPTH
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  psa_pkg::t_qcmd                     i_cmd,
    output logic [$clog2(QUEUE_DEPTH)-1:0]     o_head  [LEVELS],
    output logic [$clog2(QUEUE_DEPTH+1)-1:0]   o_count [LEVELS],
    output logic [$clog2(QUEUE_DEPTH)-1:0]     o_tail  [LEVELS]
);
    import psa_pkg::*;

    localparam int LW    = $clog2(LEVELS);
    localparam int SW    = $clog2(QUEUE_DEPTH);
    localparam int CW    = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W = CW + 1;

    logic [SW-1:0] r_head  [LEVELS];
    logic [CW-1:0] r_count [LEVELS];
    logic [SW-1:0] tail    [LEVELS];
    logic [LW-1:0] lvl;

    assign lvl = i_cmd.lvl[LW-1:0];

    always_comb begin
        logic [SUM_W-1:0] s;
        for (int l = 0; l < LEVELS; l++) begin
            s = SUM_W'(r_head[l]) + SUM_W'(r_count[l]);
            if (s >= SUM_W'(QUEUE_DEPTH)) begin
                s = s - SUM_W'(QUEUE_DEPTH);
            end
            tail[l] = s[SW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int l = 0; l < LEVELS; l++) begin
                r_head[l]  <= '0;
                r_count[l] <= '0;
            end
        end else if (i_cmd.push) begin
            r_count[lvl] <= r_count[lvl] + CW'(1);
        end else if (i_cmd.pop) begin
            r_head[lvl]  <= (r_head[lvl] == SW'(QUEUE_DEPTH - 1)) ? '0
                                                                  : r_head[lvl] + SW'(1);
            r_count[lvl] <= r_count[lvl] - CW'(1);
        end else if (i_cmd.drain) begin
            // entries stay in place and are walked by the sequencer
            r_head[lvl]  <= tail[lvl];
            r_count[lvl] <= '0;
        end
    end

    assign o_head  = r_head;
    assign o_count = r_count;
    assign o_tail  = tail;

    `PSA_ASSERT(a_push_not_full, i_clk, i_rst_n,
                !i_cmd.push || (r_count[lvl] < CW'(QUEUE_DEPTH)))
    `PSA_ASSERT(a_pop_not_empty, i_clk, i_rst_n,
                !i_cmd.pop || (r_count[lvl] != '0))
endmodule

// File: hw/rtl/psa_seq.sv
// tick sequencer: arrival intake, queue walks for cutoff and aging, slice end,
// dispatch, result register and configuration registers; depends on psa_pkg,
// psa_req_if, psa_res_if and assert_macros.svh
`include "assert_macros.svh"
module psa_seq #(
    parameter int LEVELS      = psa_pkg::DEF_LEVELS,
    parameter int QUEUE_DEPTH = psa_pkg::DEF_QUEUE_DEPTH
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    psa_req_if.sink                                    i_req,
    psa_res_if.source                                  o_res,
    input  logic                                       i_cfg_we,
    input  logic [psa_pkg::CFG_IDX_W-1:0]              i_cfg_idx,
    input  logic [psa_pkg::CFG_DATA_W-1:0]             i_cfg_data,
    output psa_pkg::t_qcmd                             o_qcmd,
    input  logic [$clog2(QUEUE_DEPTH)-1:0]             i_head  [LEVELS],
    input  logic [$clog2(QUEUE_DEPTH+1)-1:0]           i_count [LEVELS],
    input  logic [$clog2(QUEUE_DEPTH)-1:0]             i_tail  [LEVELS],
    output logic                                       o_we,
    output logic [$clog2(LEVELS*QUEUE_DEPTH)-1:0]      o_waddr,
    output logic [psa_pkg::JOB_W-1:0]                  o_wdata,
    output logic                                       o_re,
    output logic [$clog2(LEVELS*QUEUE_DEPTH)-1:0]      o_raddr,
    input  logic [psa_pkg::JOB_W-1:0]                  i_rdata
);
    import psa_pkg::*;

    localparam int LW = $clog2(LEVELS);
    localparam int SW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int AW = $clog2(LEVELS * QUEUE_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE, S_LVL_INIT, S_RD, S_EVAL, S_RUN, S_DISP, S_DISP2, S_EMIT
    } t_state;

    t_state        r_state, n_state, r_ret, n_ret;
    logic          r_pass_age, n_pass_age;
    logic [LW-1:0] r_lvl, n_lvl;
    logic [SW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_left, n_left;
    t_job          r_run, n_run;
    logic          r_busy, n_busy;
    logic [15:0]   r_clock, n_clock;
    logic [15:0]   r_cutoff, n_cutoff;
    logic [3:0]    r_age_lim, n_age_lim;
    t_res          r_res, n_res;
    logic          r_out_valid, n_out_valid;
    t_res          r_out, n_out;

    function automatic logic [AW-1:0] f_addr(input logic [LW-1:0] l,
                                             input logic [SW-1:0] s);
        f_addr = AW'(AW'(l) * AW'(QUEUE_DEPTH)) + AW'(s);
    endfunction

    function automatic t_res f_res(input t_event k, input t_job j,
                                   input logic [15:0] st, input logic [15:0] et,
                                   input logic lst);
        t_res r;
        r.kind     = k;
        r.id       = j.id;
        r.prio     = 3'(4'(j.lvl) + 4'd1);
        r.arrival  = j.arrival;
        r.service  = j.service;
        r.start    = st;
        r.end_tick = et;
        r.last     = lst;
        f_res = r;
    endfunction

    always_comb begin
        t_job          a_job, j, rj;
        logic [2:0]    pr;
        logic [3:0]    aged;
        logic [LW-1:0] own, best;
        logic          waiting, any, done, out_free;
        logic [7:0]    rem;

        n_state     = r_state;
        n_ret       = r_ret;
        n_pass_age  = r_pass_age;
        n_lvl       = r_lvl;
        n_rd        = r_rd;
        n_left      = r_left;
        n_run       = r_run;
        n_busy      = r_busy;
        n_clock     = r_clock;
        n_cutoff    = r_cutoff;
        n_age_lim   = r_age_lim;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid && !o_res.ready;
        out_free    = !r_out_valid || o_res.ready;

        o_qcmd  = '0;
        o_we    = 1'b0;
        o_waddr = '0;
        o_wdata = '0;
        o_re    = 1'b0;
        o_raddr = '0;

        // arriving job, priority clamped into the level range
        pr = i_req.job_priority;
        a_job.id        = i_req.job_id;
        if (pr == 3'd0) begin
            a_job.lvl = '0;
        end else if (4'(pr) > 4'(LEVELS)) begin
            a_job.lvl = LVL_W'(LEVELS - 1);
        end else begin
            a_job.lvl = pr - 3'd1;
        end
        a_job.arrival   = r_clock;
        a_job.service   = i_req.job_service;
        a_job.remaining = i_req.job_service;
        a_job.start     = '0;
        a_job.age       = '0;

        j    = t_job'(i_rdata);
        aged = (j.age == AGE_MAX) ? AGE_MAX : j.age + 4'd1;

        own     = r_run.lvl[LW-1:0];
        waiting = 1'b0;
        any     = 1'b0;
        best    = '0;
        for (int l = LEVELS - 1; l >= 0; l--) begin
            if (i_count[l] != '0) begin
                any  = 1'b1;
                best = LW'(l);
                if (LW'(l) <= own) begin
                    waiting = 1'b1;
                end
            end
        end
        done = r_run.remaining <= 8'd1;
        rem  = (r_run.remaining != 8'd0) ? r_run.remaining - 8'd1 : 8'd0;
        rj   = r_run;
        rj.remaining = rem;
        rj.age       = '0;

        case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    if (i_req.req_type == REQ_ARRIVAL) begin
                        if (i_count[a_job.lvl[LW-1:0]] < CW'(QUEUE_DEPTH)) begin
                            o_qcmd.push = 1'b1;
                            o_qcmd.lvl  = a_job.lvl;
                            o_we        = 1'b1;
                            o_waddr     = f_addr(a_job.lvl[LW-1:0],
                                                 i_tail[a_job.lvl[LW-1:0]]);
                            o_wdata     = a_job;
                        end else begin
                            n_res   = f_res(EV_REJECT, a_job, '0, r_clock, 1'b1);
                            n_ret   = S_IDLE;
                            n_state = S_EMIT;
                        end
                    end else if (r_clock == r_cutoff) begin
                        n_pass_age = 1'b0;
                        n_lvl      = '0;
                        n_state    = S_LVL_INIT;
                    end else if (r_busy) begin
                        n_pass_age = 1'b1;
                        n_lvl      = LW'(1);
                        n_state    = S_LVL_INIT;
                    end else begin
                        n_state = S_RUN;
                    end
                end
            end
            S_LVL_INIT: begin
                n_rd         = i_head[r_lvl];
                n_left       = i_count[r_lvl];
                o_qcmd.drain = 1'b1;
                o_qcmd.lvl   = LVL_W'(r_lvl);
                n_state      = S_RD;
            end
            S_RD: begin
                if (r_left == '0) begin
                    if (r_lvl != LW'(LEVELS - 1)) begin
                        n_lvl   = r_lvl + LW'(1);
                        n_state = S_LVL_INIT;
                    end else if (!r_pass_age && r_busy) begin
                        n_pass_age = 1'b1;
                        n_lvl      = LW'(1);
                        n_state    = S_LVL_INIT;
                    end else begin
                        n_state = S_RUN;
                    end
                end else begin
                    o_re    = 1'b1;
                    o_raddr = f_addr(r_lvl, r_rd);
                    n_rd    = (r_rd == SW'(QUEUE_DEPTH - 1)) ? '0 : r_rd + SW'(1);
                    n_left  = r_left - CW'(1);
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                n_state = S_RD;
                if (!r_pass_age) begin
                    // started jobs survive the cutoff
                    if (j.remaining < j.service) begin
                        o_qcmd.push = 1'b1;
                        o_qcmd.lvl  = LVL_W'(r_lvl);
                        o_we        = 1'b1;
                        o_waddr     = f_addr(r_lvl, i_tail[r_lvl]);
                        o_wdata     = j;
                    end else begin
                        n_res   = f_res(EV_DROP, j, '0, r_clock, 1'b0);
                        n_ret   = S_RD;
                        n_state = S_EMIT;
                    end
                end else if (aged > r_age_lim &&
                             i_count[r_lvl - LW'(1)] < CW'(QUEUE_DEPTH)) begin
                    o_qcmd.push = 1'b1;
                    o_qcmd.lvl  = LVL_W'(r_lvl - LW'(1));
                    o_we        = 1'b1;
                    o_waddr     = f_addr(r_lvl - LW'(1), i_tail[r_lvl - LW'(1)]);
                    o_wdata     = {j.id, LVL_W'(r_lvl - LW'(1)), j.arrival, j.service,
                                   j.remaining, j.start, 4'd0};
                end else begin
                    o_qcmd.push = 1'b1;
                    o_qcmd.lvl  = LVL_W'(r_lvl);
                    o_we        = 1'b1;
                    o_waddr     = f_addr(r_lvl, i_tail[r_lvl]);
                    o_wdata     = {j.id, j.lvl, j.arrival, j.service,
                                   j.remaining, j.start, aged};
                end
            end
            S_RUN: begin
                n_ret   = S_DISP;
                n_state = S_EMIT;
                if (!r_busy) begin
                    n_res = f_res(EV_IDLE, '0, '0, r_clock, 1'b1);
                    n_res.prio = '0;
                end else begin
                    n_res = f_res(done ? EV_FINISH : EV_SLICE, r_run, r_run.start,
                                  r_clock, 1'b1);
                    n_run.remaining = rem;
                    if (done) begin
                        n_busy = 1'b0;
                    end else if (waiting && i_count[own] < CW'(QUEUE_DEPTH)) begin
                        // preempted by waiting peers or better work
                        o_qcmd.push = 1'b1;
                        o_qcmd.lvl  = r_run.lvl;
                        o_we        = 1'b1;
                        o_waddr     = f_addr(own, i_tail[own]);
                        o_wdata     = rj;
                        n_busy      = 1'b0;
                    end
                end
            end
            S_DISP: begin
                if (!r_busy && any) begin
                    o_re        = 1'b1;
                    o_raddr     = f_addr(best, i_head[best]);
                    o_qcmd.pop  = 1'b1;
                    o_qcmd.lvl  = LVL_W'(best);
                    n_state     = S_DISP2;
                end else begin
                    n_clock = r_clock + 16'd1;
                    n_state = S_IDLE;
                end
            end
            S_DISP2: begin
                n_run = j;
                if (j.remaining == j.service) begin
                    n_run.start = r_clock;
                end
                n_run.age = '0;
                n_busy    = 1'b1;
                n_clock   = r_clock + 16'd1;
                n_state   = S_IDLE;
            end
            S_EMIT: begin
                if (out_free) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = r_ret;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_CUTOFF:    n_cutoff  = i_cfg_data;
                CFG_AGE_LIMIT: n_age_lim = i_cfg_data[3:0];
                default:       n_cutoff  = r_cutoff;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ret       <= S_IDLE;
            r_pass_age  <= 1'b0;
            r_lvl       <= '0;
            r_left      <= '0;
            r_busy      <= 1'b0;
            r_clock     <= '0;
            r_cutoff    <= CUTOFF_RST;
            r_age_lim   <= AGE_LIMIT_RST;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ret       <= n_ret;
            r_pass_age  <= n_pass_age;
            r_lvl       <= n_lvl;
            r_left      <= n_left;
            r_busy      <= n_busy;
            r_clock     <= n_clock;
            r_cutoff    <= n_cutoff;
            r_age_lim   <= n_age_lim;
            r_out_valid <= n_out_valid;
        end
        r_rd  <= n_rd;
        r_run <= n_run;
        r_res <= n_res;
        r_out <= n_out;
    end

    assign i_req.ready        = (r_state == S_IDLE);
    assign o_res.valid        = r_out_valid;
    assign o_res.event_kind   = r_out.kind;
    assign o_res.out_id       = r_out.id;
    assign o_res.out_priority = r_out.prio;
    assign o_res.out_arrival  = r_out.arrival;
    assign o_res.out_service  = r_out.service;
    assign o_res.out_start    = r_out.start;
    assign o_res.out_end      = r_out.end_tick;
    assign o_res.last_result  = r_out.last;

    `PSA_ASSERT_NEXT(a_dispatch_busy, i_clk, i_rst_n, r_state == S_DISP2, r_busy)
    `PSA_ASSERT_NEXT(a_dispatch_clock, i_clk, i_rst_n, r_state == S_DISP2,
                     r_clock == $past(r_clock) + 16'd1)
    `PSA_ASSERT(a_age_pass_busy, i_clk, i_rst_n,
                !(r_state == S_EVAL && r_pass_age) || r_busy)
endmodule

// File: hw/rtl/priority_scheduler_with_aging.sv
// Preemptive four-level scheduler with aging. An arrival is accepted while the
// sequencer is idle and written into its level queue; a rejected one gives a
// reject result. A tick walks the level queues in the queue memory, each entry
// read in S_RD and then evaluated in S_EVAL: at the cutoff tick every queued
// entry is walked and each dropped job gives a drop result, and while a job runs
// the entries of levels 2 and below are walked for aging; the slice result and
// dispatch follow. The result register lets a result wait while work goes on.
// Depends on psa_pkg, psa_req_if, psa_res_if, psa_ram, psa_qptr and psa_seq.
module priority_scheduler_with_aging #(
    parameter int LEVELS      = psa_pkg::DEF_LEVELS,
    parameter int QUEUE_DEPTH = psa_pkg::DEF_QUEUE_DEPTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    psa_req_if.sink                        i_req,
    psa_res_if.source                      o_res,
    input  logic                           i_cfg_we,
    input  logic [psa_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [psa_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import psa_pkg::*;

    localparam int SW    = $clog2(QUEUE_DEPTH);
    localparam int CW    = $clog2(QUEUE_DEPTH + 1);
    localparam int DEPTH = LEVELS * QUEUE_DEPTH;
    localparam int AW    = $clog2(DEPTH);

    t_qcmd          qcmd;
    logic [SW-1:0]  head  [LEVELS];
    logic [CW-1:0]  count [LEVELS];
    logic [SW-1:0]  tail  [LEVELS];
    logic           we, re;
    logic [AW-1:0]  waddr, raddr;
    logic [JOB_W-1:0] wdata, rdata;

    psa_ram #(.WIDTH(JOB_W), .DEPTH(DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    psa_qptr #(.LEVELS(LEVELS), .QUEUE_DEPTH(QUEUE_DEPTH)) u_qptr (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (qcmd),
        .o_head  (head),
        .o_count (count),
        .o_tail  (tail)
    );

    psa_seq #(.LEVELS(LEVELS), .QUEUE_DEPTH(QUEUE_DEPTH)) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (i_req),
        .o_res      (o_res),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_qcmd     (qcmd),
        .i_head     (head),
        .i_count    (count),
        .i_tail     (tail),
        .o_we       (we),
        .o_waddr    (waddr),
        .o_wdata    (wdata),
        .o_re       (re),
        .o_raddr    (raddr),
        .i_rdata    (rdata)
    );
endmodule
